// ===== sv/servo_status_packet_receiver_macros.svh =====
// ----------------------------------------------------------------------------
// servo_status_packet_receiver assertion macros
// Shared concurrent assertion forms for the receiver checkers.
// ----------------------------------------------------------------------------
`ifndef SERVO_STATUS_PACKET_RECEIVER_MACROS_SVH
`define SERVO_STATUS_PACKET_RECEIVER_MACROS_SVH

// same-cycle implication
`define SSPR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSPR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sspr_pkg.sv =====
// ----------------------------------------------------------------------------
// sspr_pkg
// Shared codes, constants and types of the servo status packet receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sspr_pkg;

  localparam logic [1:0] OP_ARM  = 2'd0;
  localparam logic [1:0] OP_BYTE = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_CORRUPT = 2'd2;

  localparam logic [7:0]  HDR_BYTE    = 8'hFF;
  localparam logic [15:0] TIMEOUT_RST = 16'd2000;

  localparam int GOT_W      = 8;
  localparam int OUT_DATA_W = 32;

  typedef struct packed {
    logic             fin;
    logic [GOT_W-1:0] got;
    logic [1:0]       status;
    logic [6:0]       flags;
    logic [7:0]       pcount;
  } fin_req_t;

endpackage

`default_nettype wire

// ===== sv/sspr_param_ram.sv =====
// ----------------------------------------------------------------------------
// sspr_param_ram
// Parameter byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sspr_param_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/sspr_parser.sv =====
// ----------------------------------------------------------------------------
// sspr_parser
// Packet state: header hunt, field capture, checksum and idle timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module sspr_parser #(
  parameter int MAX_PARAMS = 16,
  parameter int AW         = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [1:0]        opcode,
  input  wire logic [7:0]        rx_byte,
  input  wire logic              cfg_wen,
  input  wire logic [15:0]       cfg_wdata,
  output logic                   mem_we,
  output logic      [AW-1:0]     mem_waddr,
  output logic      [7:0]        mem_wdata,
  output sspr_pkg::fin_req_t     fin_req
);

  import sspr_pkg::*;

  logic        armed, armed_next;
  logic [8:0]  bpos, bpos_next;
  logic        hdr_found, hdr_found_next;
  logic [7:0]  len_byte, len_byte_next;
  logic [7:0]  err_byte, err_byte_next;
  logic [7:0]  sum_acc, sum_acc_next;
  logic [15:0] idle_cnt, idle_cnt_next;
  logic [15:0] idle_timeout;

  logic [8:0]  k, pidx, fin_k, gk, got9;
  logic [15:0] idle_inc;
  logic        do_fin;
  logic [1:0]  fin_st;
  logic [6:0]  fin_fl;

  always_comb begin
    armed_next     = armed;
    bpos_next      = bpos;
    hdr_found_next = hdr_found;
    len_byte_next  = len_byte;
    err_byte_next  = err_byte;
    sum_acc_next   = sum_acc;
    idle_cnt_next  = idle_cnt;
    mem_we         = 1'b0;
    do_fin         = 1'b0;
    fin_k          = 9'd0;
    fin_st         = ST_OK;
    fin_fl         = 7'd0;
    k              = bpos - 9'd2;
    pidx           = k - 9'd3;
    idle_inc       = (idle_cnt != 16'hFFFF) ? idle_cnt + 16'd1 : idle_cnt;

    if (accept) begin
      priority if (opcode == OP_ARM) begin
        armed_next     = 1'b1;
        bpos_next      = 9'd0;
        hdr_found_next = 1'b0;
        len_byte_next  = 8'd0;
        err_byte_next  = 8'd0;
        sum_acc_next   = 8'd0;
        idle_cnt_next  = 16'd0;
      end else if (armed && opcode == OP_TICK) begin
        idle_cnt_next = idle_inc;
        if (idle_inc >= idle_timeout) begin
          do_fin = 1'b1;
          fin_st = hdr_found ? ST_CORRUPT : ST_TIMEOUT;
          fin_k  = hdr_found ? k : 9'd0;
        end
      end else if (armed && opcode == OP_BYTE) begin
        idle_cnt_next = 16'd0;
        if (bpos < 9'd2) begin
          bpos_next = (rx_byte == HDR_BYTE) ? bpos + 9'd1 : 9'd0;
        end else begin
          hdr_found_next = 1'b1;
          priority if (k == 9'd1) begin
            len_byte_next = rx_byte;
            if (rx_byte < 8'd2) begin
              do_fin = 1'b1;
              fin_st = ST_CORRUPT;
              fin_k  = 9'd2;
            end
          end else if (k >= 9'd2 && k == {1'b0, len_byte} + 9'd1) begin
            do_fin = 1'b1;
            fin_k  = k;
            if (rx_byte == ~sum_acc) begin
              fin_st = ST_OK;
              fin_fl = err_byte[6:0];
            end else begin
              fin_st = ST_CORRUPT;
            end
          end else if (k == 9'd2) begin
            err_byte_next = rx_byte;
          end else if (k >= 9'd3) begin
            mem_we = (pidx < 9'(MAX_PARAMS));
          end else begin
            // id byte: summed only
          end
          if (!do_fin) begin
            sum_acc_next = sum_acc + rx_byte;
            bpos_next    = bpos + 9'd1;
          end
        end
      end else begin
        // disarmed or unused opcode
      end
      if (do_fin) begin
        armed_next = 1'b0;
      end
    end
  end

  assign mem_waddr = pidx[AW-1:0];
  assign mem_wdata = rx_byte;

  assign gk   = fin_k - 9'd3;
  assign got9 = (fin_k > 9'd3) ? ((gk > 9'(MAX_PARAMS)) ? 9'(MAX_PARAMS) : gk) : 9'd0;

  always_comb begin
    fin_req.fin    = do_fin;
    fin_req.got    = GOT_W'(got9);
    fin_req.status = fin_st;
    fin_req.flags  = fin_fl;
    fin_req.pcount = (fin_k > 9'd1 && len_byte >= 8'd2) ? len_byte - 8'd2 : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed        <= 1'b0;
      bpos         <= 9'd0;
      hdr_found    <= 1'b0;
      len_byte     <= 8'd0;
      err_byte     <= 8'd0;
      sum_acc      <= 8'd0;
      idle_cnt     <= 16'd0;
      idle_timeout <= TIMEOUT_RST;
    end else begin
      armed     <= armed_next;
      bpos      <= bpos_next;
      hdr_found <= hdr_found_next;
      len_byte  <= len_byte_next;
      err_byte  <= err_byte_next;
      sum_acc   <= sum_acc_next;
      idle_cnt  <= idle_cnt_next;
      if (cfg_wen) begin
        idle_timeout <= cfg_wdata;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/sspr_emitter.sv =====
// ----------------------------------------------------------------------------
// sspr_emitter
// Walks the stored parameters out of the store, then sends the status beat.
// ----------------------------------------------------------------------------
`default_nettype none

module sspr_emitter #(
  parameter int AW = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            accept,
  input  wire sspr_pkg::fin_req_t              fin_req,
  output logic                                 s_tready,
  output logic                                 rd_en,
  output logic      [AW-1:0]                   rd_addr,
  input  wire logic [7:0]                      rd_data,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [sspr_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic      [0:0]                      m_tuser,
  output logic                                 m_tlast
);

  import sspr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_LOAD  = 5'b00100,
    S_PSEND = 5'b01000,
    S_LAST  = 5'b10000
  } emit_state_t;

  emit_state_t      state;
  logic [AW-1:0]    idx;
  logic [GOT_W-1:0] got;
  logic [1:0]       st_r;
  logic [6:0]       fl_r;
  logic             o_isp, o_last;
  logic [3:0]       o_idx;
  logic [7:0]       o_byte, o_pc;
  logic [1:0]       o_status;
  logic [6:0]       o_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && fin_req.fin) begin
            got  <= fin_req.got;
            st_r <= fin_req.status;
            fl_r <= fin_req.flags;
            o_pc <= fin_req.pcount;
            idx  <= '0;
            if (fin_req.got == '0) begin
              o_isp    <= 1'b0;
              o_idx    <= 4'd0;
              o_byte   <= 8'd0;
              o_status <= fin_req.status;
              o_flags  <= fin_req.flags;
              o_last   <= 1'b1;
              state    <= S_LAST;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          o_isp    <= 1'b1;
          o_idx    <= 4'(idx);
          o_byte   <= rd_data;
          o_status <= ST_OK;
          o_flags  <= 7'd0;
          o_last   <= 1'b0;
          state    <= S_PSEND;
        end
        S_PSEND: begin
          if (m_tready) begin
            if (GOT_W'(idx) + GOT_W'(1) == got) begin
              o_isp    <= 1'b0;
              o_idx    <= 4'd0;
              o_byte   <= 8'd0;
              o_status <= st_r;
              o_flags  <= fl_r;
              o_last   <= 1'b1;
              state    <= S_LAST;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_READ;
            end
          end
        end
        S_LAST: begin
          if (m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  assign rd_en    = (state == S_READ);
  assign rd_addr  = idx;
  assign m_tvalid = (state == S_PSEND) || (state == S_LAST);
  assign m_tuser  = o_isp;
  assign m_tlast  = o_last;
  assign m_tdata  = {3'd0, o_pc, o_flags, o_status, o_byte, o_idx};

endmodule

`default_nettype wire

// ===== sv/servo_status_packet_receiver.sv =====
// ----------------------------------------------------------------------------
// servo_status_packet_receiver
// Servo status packet receiver: header match, field capture, checksum check,
// idle timeout, and a run of parameter beats closed by one status beat.
// ----------------------------------------------------------------------------
// Input stream: s_tuser carries the opcode (arm, byte, tick), s_tdata the
// received byte.
// Output stream: one beat per stored parameter (m_tuser = 1), then one status
// beat (m_tuser = 0, m_tlast = 1) with status, error flags and the announced
// parameter count.
// A beat that ends the packet (checksum, short length or timeout) drops
// s_tready until the run has been delivered. With no stored parameters the
// status beat appears on the cycle after that beat; otherwise each parameter
// is read from the store, loaded into the output register and sent, and the
// status beat follows the last one. Any other input beat leaves s_tready high.
// m_tready low holds the current output beat; the input stays stalled.
// Reset: disarmed, idle timeout 2000 ticks, no run pending, s_tready high.
// cfg_wen/cfg_wdata write the idle timeout register.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_status_packet_receiver #(
  parameter int MAX_PARAMS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [7:0]                      s_tdata,  // rx_byte
  input  wire logic [1:0]                      s_tuser,  // opcode
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // param_index[3:0], param_byte[11:4], status[13:12], error_flags[20:14],
  // param_count[28:21], zero[31:29]
  output logic      [sspr_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic      [0:0]                      m_tuser,  // is_param
  output logic                                 m_tlast,
  input  wire logic                            cfg_wen,
  input  wire logic [15:0]                     cfg_wdata
);

  import sspr_pkg::*;

  localparam int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

  logic          accept;
  logic          mem_we, rd_en;
  logic [AW-1:0] mem_waddr, rd_addr;
  logic [7:0]    mem_wdata, rd_data;
  fin_req_t      fin_req;

  assign accept = s_tvalid && s_tready;

  sspr_parser #(
    .MAX_PARAMS(MAX_PARAMS),
    .AW        (AW)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .opcode   (s_tuser),
    .rx_byte  (s_tdata),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .fin_req  (fin_req)
  );

  sspr_param_ram #(
    .DEPTH(MAX_PARAMS),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  sspr_emitter #(
    .AW(AW)
  ) u_emitter (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .fin_req (fin_req),
    .s_tready(s_tready),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule

`default_nettype wire

// ===== sv/sspr_checker.sv =====
// ----------------------------------------------------------------------------
// sspr_checker
// Port-level checks of the servo status packet receiver, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none
`include "servo_status_packet_receiver_macros.svh"

module sspr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [0:0]  m_tuser,
  input wire logic        m_tlast
);

  `SSPR_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output beat changed while stalled")
  `SSPR_ASSERT_NOW(a_no_overlap, clk, rst, s_tready, !m_tvalid, "input ready while a result run is pending")
  `SSPR_ASSERT_NOW(a_last_is_status, clk, rst, m_tvalid, m_tlast == !m_tuser[0], "last flag does not match status beat")
  `SSPR_ASSERT_NOW(a_status_fields, clk, rst, m_tvalid && m_tlast, m_tdata[11:0] == 12'd0 && m_tdata[13:12] != 2'b11 && m_tdata[31:29] == 3'd0, "malformed status beat")
  `SSPR_ASSERT_NEXT(a_ready_after_run, clk, rst, m_tvalid && m_tready && m_tlast, s_tready, "input not released after status beat")

endmodule

bind servo_status_packet_receiver sspr_checker u_sspr_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the servo status packet receiver. Byte, tick and arm beats are
// sent into the block. A packet tracker written here follows each accepted
// beat and queues the parameter and status beats the block must return. The
// return stream is checked beat by beat in order. Both stream sides idle at
// random, the receiver holds off once for a long stretch, and the idle
// timeout register is set to short values, zero included.
// ----------------------------------------------------------------------------
module tb_top;
  import sspr_pkg::*;

  localparam int          RESET_CYCLES = 9;
  localparam int          DRAIN_CYCLES = 64;
  localparam int          LONG_HOLD    = 300;
  localparam int          WAIT_LIMIT   = 20000;
  localparam int          STORE_DEPTH  = 16;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;

  // how a sent packet ends
  localparam int END_GOOD    = 0;
  localparam int END_BAD_SUM = 1;
  localparam int END_CUT     = 2;  // stop mid-packet, tick until it times out
  localparam int END_ABANDON = 3;  // stop mid-packet, no ticks

  typedef struct packed {
    logic       is_param;
    logic [3:0] idx;
    logic [7:0] pbyte;
    logic [1:0] status;
    logic [6:0] flags;
    logic [7:0] pcount;
    logic       last;
  } rx_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [7:0]            s_tdata;
  logic [1:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0]            m_tuser;
  logic                  m_tlast;
  logic                  cfg_wen;
  logic [15:0]           cfg_wdata;

  int send_gap_pct  = 0;
  int stall_pct     = 0;
  int live_beats    = 0;
  int mismatch_cnt  = 0;
  bit long_hold_go  = 1'b0;

  // packet tracker state
  bit         pk_armed;
  int         pk_pos;
  bit         pk_hdr;
  logic [7:0] pk_len;
  logic [7:0] pk_err;
  logic [7:0] pk_sum;
  logic [7:0] pk_store [STORE_DEPTH];
  logic [15:0] pk_idle;
  logic [15:0] pk_timeout;

  rx_result_t packet_results_q [$];

  servo_status_packet_receiver u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatch_cnt++;
  endtask

  function automatic rx_result_t make_result(logic isp, logic [3:0] idx, logic [7:0] pb,
                                             logic [1:0] st, logic [6:0] fl,
                                             logic [7:0] pc, logic lst);
    rx_result_t r;
    r.is_param = isp;
    r.idx      = idx;
    r.pbyte    = pb;
    r.status   = st;
    r.flags    = fl;
    r.pcount   = pc;
    r.last     = lst;
    return r;
  endfunction

  // k: index of the next packet byte not yet taken (0 = id)
  function automatic void close_run(int k, logic [1:0] st, logic [6:0] fl);
    int         got;
    int         i;
    logic [7:0] pc;
    got = (k > 3) ? k - 3 : 0;
    if (got > STORE_DEPTH) got = STORE_DEPTH;
    pc = (k > 1 && pk_len >= 8'd2) ? pk_len - 8'd2 : 8'd0;
    for (i = 0; i < got; i++)
      packet_results_q.push_back(make_result(1'b1, i[3:0], pk_store[i[3:0]], ST_OK, 7'd0,
                                             pc, 1'b0));
    packet_results_q.push_back(make_result(1'b0, 4'd0, 8'd0, st, fl, pc, 1'b1));
    pk_armed = 1'b0;
  endfunction

  function automatic void clear_run();
    pk_pos  = 0;
    pk_hdr  = 1'b0;
    pk_len  = 8'd0;
    pk_err  = 8'd0;
    pk_sum  = 8'd0;
    pk_idle = 16'd0;
  endfunction

  function automatic void track_beat(logic [1:0] op, logic [7:0] b);
    int k;
    if (op == OP_ARM) begin
      clear_run();
      pk_armed = 1'b1;
      return;
    end
    if (!pk_armed || op == OP_UNUSED) return;
    if (op == OP_TICK) begin
      if (pk_idle != 16'hFFFF) pk_idle++;
      if (pk_idle >= pk_timeout) begin
        if (!pk_hdr) close_run(0, ST_TIMEOUT, 7'd0);
        else close_run(pk_pos - 2, ST_CORRUPT, 7'd0);
      end
      return;
    end
    pk_idle = 16'd0;
    if (pk_pos < 2) begin
      pk_pos = (b == HDR_BYTE) ? pk_pos + 1 : 0;
      return;
    end
    k = pk_pos - 2;
    pk_hdr = 1'b1;
    if (k == 1) begin
      pk_len = b;
      if (b < 8'd2) begin
        close_run(2, ST_CORRUPT, 7'd0);
        return;
      end
    end else if (k >= 2 && k == int'(pk_len) + 1) begin
      if (b == ~pk_sum) close_run(k, ST_OK, pk_err[6:0]);
      else close_run(k, ST_CORRUPT, 7'd0);
      return;
    end else if (k == 2) begin
      pk_err = b;
    end else if (k >= 3 && k - 3 < STORE_DEPTH) begin
      pk_store[4'(k - 3)] = b;
    end
    pk_sum = pk_sum + b;
    pk_pos++;
  endfunction

  always @(posedge clk) begin : result_check
    rx_result_t    w;
    logic [31:0]   wd;
    if (!rst && m_tvalid && m_tready) begin
      if (packet_results_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat user=%0d last=%0d data=%h",
                                  m_tuser, m_tlast, m_tdata));
      end else begin
        w  = packet_results_q.pop_front();
        wd = {3'b000, w.pcount, w.flags, w.status, w.pbyte, w.idx};
        if (m_tdata !== wd || m_tuser[0] !== w.is_param || m_tlast !== w.last)
          report_mismatch($sformatf("got user=%0d last=%0d data=%h, want user=%0d last=%0d data=%h",
                                    m_tuser, m_tlast, m_tdata, w.is_param, w.last, wd));
      end
    end
  end

  // output side ready, with one long hold-off on request
  initial begin : sink_ready
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_go) begin
        long_hold_go = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_beat(input logic [1:0] op, input logic [7:0] b);
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      s_tuser  <= 2'($urandom);
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    if (op == OP_ARM || pk_armed) live_beats++;
    track_beat(op, b);
  endtask

  task automatic wait_results(input int extra);
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (packet_results_q.size() != 0 && waited < WAIT_LIMIT);
    if (packet_results_q.size() != 0) begin
      report_mismatch($sformatf("%0d result beats never arrived", packet_results_q.size()));
      packet_results_q.delete();
    end
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    wait_results(DRAIN_CYCLES);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    pk_timeout = v;
  endtask

  task automatic send_rx_byte(input logic [7:0] b, input int tick_pct);
    if ($urandom_range(99) < tick_pct)
      repeat ($urandom_range(1, 2)) send_beat(OP_TICK, 8'($urandom));
    send_beat(OP_BYTE, b);
  endtask

  task automatic tick_out();
    while (pk_armed) send_beat(OP_TICK, 8'($urandom));
  endtask

  task automatic send_packet(input logic [7:0] id, input logic [7:0] len,
                             input logic [7:0] err, input int ending, input int tick_pct);
    logic [7:0] sum;
    logic [7:0] b;
    int         cut;
    int         i;
    sum = id + len;
    cut = (ending == END_CUT || ending == END_ABANDON) && len >= 8'd2 ?
          $urandom_range(0, int'(len) - 2) : -1;
    send_rx_byte(HDR_BYTE, tick_pct);
    send_rx_byte(HDR_BYTE, tick_pct);
    send_rx_byte(id, tick_pct);
    send_rx_byte(len, tick_pct);
    if (len < 8'd2) return;
    send_rx_byte(err, tick_pct);
    sum = sum + err;
    for (i = 0; i < int'(len) - 2 && i != cut; i++) begin
      b   = 8'($urandom);
      sum = sum + b;
      send_rx_byte(b, tick_pct);
    end
    case (ending)
      END_GOOD:    send_rx_byte(~sum, tick_pct);
      END_BAD_SUM: send_rx_byte(~sum ^ 8'($urandom_range(1, 255)), tick_pct);
      END_CUT:     tick_out();
      default:     ;
    endcase
  endtask

  task automatic test_directed_fields();
    // disarmed: all ignored
    send_beat(OP_BYTE, 8'hFF);
    send_beat(OP_TICK, 8'h00);
    send_beat(OP_UNUSED, 8'hA5);
    send_beat(OP_ARM, 8'h00);
    // broken header, then a full one; error bit 7 must be dropped
    send_beat(OP_BYTE, HDR_BYTE);
    send_beat(OP_BYTE, 8'h00);
    send_beat(OP_UNUSED, 8'h5A);
    send_packet(8'h00, 8'h02, 8'hFF, END_GOOD, 0);
    send_beat(OP_ARM, 8'hFF);
    send_packet(8'hFE, 8'h01, 8'h00, END_GOOD, 0);
    send_beat(OP_ARM, 8'h00);
    send_packet(8'h01, 8'h03, 8'h00, END_BAD_SUM, 0);
    send_beat(OP_ARM, 8'h00);
    send_packet(8'hFF, 8'h05, 8'h7F, END_GOOD, 0);
  endtask

  task automatic test_framing_errors();
    send_beat(OP_ARM, 8'h00);
    send_packet(8'h05, 8'h06, 8'h00, END_ABANDON, 0);
    send_beat(OP_ARM, 8'h00);   // re-arm mid-packet
    send_packet(8'h05, 8'h02, 8'h00, END_GOOD, 0);
    send_beat(OP_ARM, 8'h00);
    send_packet(8'h10, 8'h00, 8'h00, END_GOOD, 0);
    send_beat(OP_ARM, 8'h00);
    send_packet(8'h20, 8'd20, 8'h21, END_GOOD, 0);
    send_beat(OP_ARM, 8'h00);
    send_packet(8'hFD, 8'h03, 8'h80, END_GOOD, 0);
  endtask

  task automatic test_backpressure();
    wait_results(DRAIN_CYCLES);
    long_hold_go = 1'b1;
    send_beat(OP_ARM, 8'($urandom));
    send_packet(8'($urandom), 8'd18, 8'($urandom), END_GOOD, 0);
    wait_results(0);
    send_beat(OP_ARM, 8'($urandom));
    send_packet(8'($urandom), 8'd9, 8'($urandom), END_BAD_SUM, 0);
  endtask

  task automatic test_timeouts();
    write_timeout(16'd1);
    send_beat(OP_ARM, 8'h00);
    send_beat(OP_BYTE, HDR_BYTE);
    send_beat(OP_BYTE, HDR_BYTE);
    send_beat(OP_BYTE, 8'h33);
    tick_out();
    send_beat(OP_ARM, 8'h00);
    send_packet(8'h44, 8'h07, 8'h03, END_CUT, 0);
    write_timeout(16'd0);
    send_beat(OP_ARM, 8'h00);
    send_beat(OP_TICK, 8'hC3);
    write_timeout(16'd2);
    send_beat(OP_ARM, 8'h00);
    send_beat(OP_TICK, 8'h00);
    send_beat(OP_BYTE, 8'h00);
    tick_out();
  endtask

  task automatic test_random_traffic(input int beats);
    int         stop_at;
    int         r;
    int         ending;
    logic [7:0] len;
    write_timeout(16'($urandom_range(3, 24)));
    stop_at = live_beats + beats;
    while (live_beats < stop_at) begin
      r = $urandom_range(99);
      if (r < 4) begin
        wait_results(0);
      end else if (r < 10) begin
        send_beat(2'($urandom_range(1, 3)), 8'($urandom));
      end else begin
        r = $urandom_range(99);
        if (r < 6) len = 8'($urandom_range(0, 1));
        else if (r < 14) len = 8'($urandom_range(17, 20));
        else if (r < 22) len = 8'($urandom_range(10, 16));
        else len = 8'($urandom_range(2, 9));
        r = $urandom_range(99);
        ending = (r < 60) ? END_GOOD : (r < 72) ? END_BAD_SUM : (r < 88) ? END_CUT : END_ABANDON;
        if ($urandom_range(9) != 0) send_beat(OP_ARM, 8'($urandom));
        send_packet(8'($urandom), len, 8'($urandom), ending, 10);
      end
    end
  endtask

  initial begin : stimulus
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = 8'd0;
    s_tuser    = OP_ARM;
    cfg_wen    = 1'b0;
    cfg_wdata  = 16'd0;
    pk_armed   = 1'b0;
    pk_timeout = TIMEOUT_RST;
    clear_run();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_gap_pct = 10;
    stall_pct    = 88;
    test_directed_fields();
    test_framing_errors();
    test_backpressure();
    test_timeouts();
    test_random_traffic(40);

    send_gap_pct = 88;
    stall_pct    = 10;
    test_random_traffic(40);

    send_gap_pct = 0;
    stall_pct    = 0;
    test_random_traffic(30);

    wait_results(DRAIN_CYCLES);
    if (mismatch_cnt == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== servo_status_packet_receiver.f =====
+incdir+sv
sv/sspr_pkg.sv
sv/sspr_param_ram.sv
sv/sspr_parser.sv
sv/sspr_emitter.sv
sv/servo_status_packet_receiver.sv
sv/sspr_checker.sv
tb/tb_top.sv
